@@ hw/rtl/csv_pkg.sv @@
// Shared types, constants and helper functions of the crank-slider step solver.
package csv_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int RELAX_PASSES = 8;
	localparam int PASS_W       = $clog2(RELAX_PASSES + 1);
	localparam int ANG_FRAC     = 24;
	localparam int CORDIC_STEPS = 24;
	localparam int ANG_SHIFT    = ANG_FRAC - FRAC_BITS;

	typedef logic signed [41:0] wide_t;
	typedef logic signed [31:0] fix_t;
	typedef logic signed [51:0] cord_t;
	typedef logic signed [33:0] ang_t;

	localparam logic [2:0] REG_CX  = 3'd0;
	localparam logic [2:0] REG_CY  = 3'd1;
	localparam logic [2:0] REG_RAD = 3'd2;
	localparam logic [2:0] REG_LEN = 3'd3;

	localparam logic [11:0] CX_RST  = 12'd960;
	localparam logic [11:0] CY_RST  = 12'd720;
	localparam logic [9:0]  RAD_RST = 10'd100;
	localparam logic [11:0] LEN_RST = 12'd300;

	// Split factors 0.95 and 0.05 rounded to FRAC_BITS.
	localparam logic [31:0] K_PISTON = 32'(((64'd95 << FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic [31:0] K_PIN    = 32'(((64'd5 << FRAC_BITS) + 64'd50) / 64'd100);

	localparam logic [32:0] ATERM_DIV  = 33'd1000000;
	localparam logic [32:0] ATERM_HALF = 33'd500000;

	function automatic fix_t sat32(wide_t v);
		if (v > wide_t'(32'sh7fffffff)) return 32'sh7fffffff;
		if (v < wide_t'(-32'sh7fffffff - 1)) return -32'sh7fffffff - 1;
		return fix_t'(v);
	endfunction

	function automatic logic [31:0] mag32(fix_t v);
		logic signed [32:0] e;
		e = 33'(v);
		return v[31] ? 32'(-e) : 32'(e);
	endfunction

	function automatic wide_t round_sh(wide_t v, int s);
		wide_t m;
		wide_t h;
		m = (v < 0) ? -v : v;
		h = (s == 0) ? '0 : (wide_t'(1) <<< (s - 1));
		m = (m + h) >>> s;
		return (v < 0) ? -m : m;
	endfunction

	localparam fix_t RST_PISTON = sat32((wide_t'(CY_RST) <<< FRAC_BITS)
		- (wide_t'(RAD_RST) <<< FRAC_BITS) - (wide_t'(LEN_RST) <<< FRAC_BITS));
	localparam fix_t RST_PIN_X = sat32(wide_t'(CX_RST) <<< FRAC_BITS);
	localparam fix_t RST_PIN_Y = sat32((wide_t'(CY_RST) <<< FRAC_BITS)
		- (wide_t'(RAD_RST) <<< FRAC_BITS));

	// atan(2^-i) in degrees with ANG_FRAC fraction bits.
	function automatic ang_t atan_lut(logic [4:0] i);
		case (i)
			5'd0:  return 34'sd754974720;
			5'd1:  return 34'sd445687602;
			5'd2:  return 34'sd235489089;
			5'd3:  return 34'sd119537938;
			5'd4:  return 34'sd60000934;
			5'd5:  return 34'sd30029717;
			5'd6:  return 34'sd15018523;
			5'd7:  return 34'sd7509720;
			5'd8:  return 34'sd3754917;
			5'd9:  return 34'sd1877466;
			5'd10: return 34'sd938734;
			5'd11: return 34'sd469367;
			5'd12: return 34'sd234684;
			5'd13: return 34'sd117342;
			5'd14: return 34'sd58671;
			5'd15: return 34'sd29335;
			5'd16: return 34'sd14668;
			5'd17: return 34'sd7334;
			5'd18: return 34'sd3667;
			5'd19: return 34'sd1833;
			5'd20: return 34'sd917;
			5'd21: return 34'sd458;
			5'd22: return 34'sd229;
			5'd23: return 34'sd115;
			default: return 34'sd0;
		endcase
	endfunction

endpackage

@@ hw/rtl/crank_slider_verlet_solver_unit.sv @@
// Crank-slider Verlet step solver: sequencer around shared multiply, divide, root and CORDIC.
//
//  channel  | signals                      | payload
//  ---------+------------------------------+-------------------------------------------
//  s        | s_tvalid s_tready s_tdata    | accel (32, signed Q16.16)
//  m        | m_tvalid m_tready m_tdata    | piston_y, pin_x, pin_y, rod_angle
//           | m_tuser                      | fault
//  cfg      | cfg_we cfg_idx cfg_data      | center x/y, radius, rod length
//
// One step computes the acceleration term, then runs RELAX_PASSES constraint passes, each
// with three roots, six divides and the 24-step CORDIC, which is skipped for a zero rod
// vector. A fault ends the step early.
// The input is ready only while the sequencer idles; one finished result waits in the
// output register while the next step is accepted and computed.
// Reset (arst_n low) loads the register defaults and the matching rest positions.
module crank_slider_verlet_solver_unit
	import csv_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // [31:0] accel
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // [31:0] piston_y, [63:32] pin_x, [95:64] pin_y,
	                                // [127:96] rod_angle
	output logic [0:0]   m_tuser,   // [0] fault
	input  logic         cfg_we,
	input  logic [2:0]   cfg_idx,
	input  logic [11:0]  cfg_data
);

	typedef enum logic [4:0] {
		S_IDLE, S_ATERM, S_VERLET, S_PASS, S_LEN, S_CORD, S_CHK1, S_UX, S_UY,
		S_K1, S_K2, S_K3, S_K4, S_CHK2, S_OUT,
		N_SQA, N_SQB, N_ADD, N_SQRT,
		C_INIT, C_DIV, C_MUL, C_RND,
		P_D, P_R, P_X, P_Y
	} state_t;

	state_t state_q, nret_q, sret_q, pret_q;

	logic [11:0] cfg_cx_q, cfg_cy_q, cfg_len_q;
	logic [9:0]  cfg_rad_q;

	fix_t cur_pis_q, old_pis_q, cur_pinx_q, cur_piny_q, old_pinx_q, old_piny_q;
	fix_t np_q, nx_q, ny_q, vx_q, vy_q, err_q, na_q, nb_q, sd_q, sf_q, pdx_q, pdy_q;
	wide_t ux_q, uy_q, sres_q;
	logic [31:0] len_q, slen_q, pr_q;
	ang_t ang_q, cr_z_q;
	cord_t cr_x_q, cr_y_q;
	logic [PASS_W-1:0] pass_q;
	logic acc_neg_q, pok_q, fault_q;
	logic [5:0] cnt_q;
	logic [63:0] prod_q, sq_acc_q, sq_n_q;
	logic [35:0] sq_rem_q;
	logic [31:0] sq_root_q;
	logic [32:0] dv_rem_q, dv_d_q;
	logic [30:0] dv_lo_q;
	logic m_tvalid_q;
	logic [127:0] m_tdata_q;
	logic m_fault_q;

	wide_t cx_w, cy_w, rf_w, lf_w;
	assign cx_w = wide_t'(cfg_cx_q) <<< FRAC_BITS;
	assign cy_w = wide_t'(cfg_cy_q) <<< FRAC_BITS;
	assign rf_w = wide_t'(cfg_rad_q) <<< FRAC_BITS;
	assign lf_w = wide_t'(cfg_len_q) <<< FRAC_BITS;

	// Shared multiplier operands.
	logic [31:0] mul_a, mul_b, ux_mag, uy_mag;
	assign ux_mag = (ux_q < 0) ? 32'(-ux_q) : 32'(ux_q);
	assign uy_mag = (uy_q < 0) ? 32'(-uy_q) : 32'(uy_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			N_SQA: begin mul_a = mag32(na_q); mul_b = mag32(na_q); end
			N_SQB: begin mul_a = mag32(nb_q); mul_b = mag32(nb_q); end
			C_MUL: begin mul_a = {1'b0, dv_lo_q}; mul_b = mag32(sf_q); end
			S_K1:  begin mul_a = uy_mag; mul_b = K_PISTON; end
			S_K2:  begin mul_a = ux_mag; mul_b = K_PIN; end
			S_K3:  begin mul_a = uy_mag; mul_b = K_PIN; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// Root step: bring down two bits and try the next root bit.
	logic [35:0] sq_t, sq_trial;
	assign sq_t     = {sq_rem_q[33:0], sq_n_q[63:62]};
	assign sq_trial = {2'b00, sq_root_q, 2'b01};

	// Divide step: restoring, one quotient bit a cycle.
	logic [33:0] dv_t;
	logic [31:0] sd_mag;
	assign dv_t   = {dv_rem_q, dv_lo_q[30]};
	assign sd_mag = mag32(sd_q);

	// CORDIC step.
	cord_t cr_xs, cr_ys, cr_xn, cr_yn;
	ang_t cr_zn;
	always_comb begin
		cr_xs = cr_x_q >>> cnt_q[4:0];
		cr_ys = cr_y_q >>> cnt_q[4:0];
		if (cr_y_q > 0) begin
			cr_xn = cr_x_q + cr_ys;
			cr_yn = cr_y_q - cr_xs;
			cr_zn = cr_z_q + atan_lut(cnt_q[4:0]);
		end else begin
			cr_xn = cr_x_q - cr_ys;
			cr_yn = cr_y_q + cr_xs;
			cr_zn = cr_z_q - atan_lut(cnt_q[4:0]);
		end
	end

	// Rounded magnitudes out of the multiplier.
	logic [33:0] sc_p;
	wide_t k_rnd, sc_res;
	assign sc_p   = 34'((prod_q + (64'd1 << 29)) >> 30);
	assign sc_res = ((sd_q < 0) != (sf_q < 0)) ? -wide_t'(sc_p) : wide_t'(sc_p);
	assign k_rnd  = wide_t'(41'((prod_q + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS));

	// Vectors of the pass and of the projection.
	fix_t vx_c, vy_c, pdx_c, pdy_c, err_c;
	logic [31:0] acc_mag;
	logic [32:0] acc_n;
	assign vx_c    = sat32(cx_w - wide_t'(nx_q));
	assign vy_c    = sat32(wide_t'(np_q) - wide_t'(ny_q));
	assign pdx_c   = sat32(wide_t'(nx_q) - cx_w);
	assign pdy_c   = sat32(wide_t'(ny_q) - cy_w);
	assign err_c   = sat32(lf_w - wide_t'({1'b0, len_q}));
	assign acc_mag = mag32(fix_t'(s_tdata));
	assign acc_n   = {1'b0, acc_mag} + ATERM_HALF;

	wide_t aterm;
	assign aterm = acc_neg_q ? -wide_t'(dv_lo_q) : wide_t'(dv_lo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			nret_q     <= S_IDLE;
			sret_q     <= S_IDLE;
			pret_q     <= S_IDLE;
			cfg_cx_q   <= CX_RST;
			cfg_cy_q   <= CY_RST;
			cfg_rad_q  <= RAD_RST;
			cfg_len_q  <= LEN_RST;
			cur_pis_q  <= RST_PISTON;
			old_pis_q  <= RST_PISTON;
			cur_pinx_q <= RST_PIN_X;
			old_pinx_q <= RST_PIN_X;
			cur_piny_q <= RST_PIN_Y;
			old_piny_q <= RST_PIN_Y;
			m_tvalid_q <= 1'b0;
			pass_q     <= '0;
			cnt_q      <= '0;
			pok_q      <= 1'b0;
			fault_q    <= 1'b0;
		end else begin
			prod_q <= mul_a * mul_b;
			if (cfg_we) begin
				case (cfg_idx)
					REG_CX:  cfg_cx_q  <= cfg_data;
					REG_CY:  cfg_cy_q  <= cfg_data;
					REG_RAD: cfg_rad_q <= cfg_data[9:0];
					REG_LEN: cfg_len_q <= cfg_data;
					default: ;
				endcase
			end
			// The output state reloads the register itself when it hands over a result.
			if (m_tvalid_q && m_tready && state_q != S_OUT) m_tvalid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						acc_neg_q <= s_tdata[31];
						fault_q   <= 1'b0;
						dv_rem_q  <= {31'd0, acc_n[32:31]};
						dv_lo_q   <= acc_n[30:0];
						dv_d_q    <= ATERM_DIV;
						cnt_q     <= '0;
						state_q   <= S_ATERM;
					end
				end
				S_ATERM, C_DIV: begin
					if (dv_t >= {1'b0, dv_d_q}) begin
						dv_rem_q <= 33'(dv_t - {1'b0, dv_d_q});
						dv_lo_q  <= {dv_lo_q[29:0], 1'b1};
					end else begin
						dv_rem_q <= dv_t[32:0];
						dv_lo_q  <= {dv_lo_q[29:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd30) state_q <= (state_q == S_ATERM) ? S_VERLET : C_MUL;
				end
				S_VERLET: begin
					np_q    <= sat32(2 * wide_t'(cur_pis_q) - wide_t'(old_pis_q) + aterm);
					nx_q    <= sat32(2 * wide_t'(cur_pinx_q) - wide_t'(old_pinx_q));
					ny_q    <= sat32(2 * wide_t'(cur_piny_q) - wide_t'(old_piny_q));
					pass_q  <= '0;
					state_q <= S_PASS;
				end
				S_PASS: begin
					vx_q    <= vx_c;
					vy_q    <= vy_c;
					na_q    <= vx_c;
					nb_q    <= vy_c;
					nret_q  <= S_LEN;
					state_q <= N_SQA;
				end
				S_LEN: begin
					len_q  <= sq_root_q;
					cnt_q  <= '0;
					pret_q <= S_CHK1;
					if (vx_q == 0 && vy_q == 0) begin
						// A zero rod vector reads as an angle of zero.
						ang_q   <= '0;
						state_q <= P_D;
					end else begin
						if (vx_q < 0) begin
							if (vy_q >= 0) begin
								cr_x_q <= cord_t'(vy_q) <<< 16;
								cr_y_q <= -(cord_t'(vx_q) <<< 16);
								cr_z_q <= ang_t'(90) <<< ANG_FRAC;
							end else begin
								cr_x_q <= -(cord_t'(vy_q) <<< 16);
								cr_y_q <= cord_t'(vx_q) <<< 16;
								cr_z_q <= -(ang_t'(90) <<< ANG_FRAC);
							end
						end else begin
							cr_x_q <= cord_t'(vx_q) <<< 16;
							cr_y_q <= cord_t'(vy_q) <<< 16;
							cr_z_q <= '0;
						end
						state_q <= S_CORD;
					end
				end
				S_CORD: begin
					cr_x_q <= cr_xn;
					cr_y_q <= cr_yn;
					cr_z_q <= cr_zn;
					cnt_q  <= cnt_q + 6'd1;
					if (cnt_q == 6'(CORDIC_STEPS - 1)) begin
						ang_q   <= cr_zn;
						state_q <= P_D;
					end
				end
				S_CHK1: begin
					if (!pok_q || len_q == 0) begin
						fault_q <= 1'b1;
						state_q <= S_OUT;
					end else begin
						err_q   <= err_c;
						sd_q    <= vx_q;
						sf_q    <= err_c;
						slen_q  <= len_q;
						sret_q  <= S_UX;
						state_q <= C_INIT;
					end
				end
				S_UX: begin
					ux_q    <= sres_q;
					sd_q    <= vy_q;
					sf_q    <= err_q;
					slen_q  <= len_q;
					sret_q  <= S_UY;
					state_q <= C_INIT;
				end
				S_UY: begin
					uy_q    <= sres_q;
					state_q <= S_K1;
				end
				S_K1: state_q <= S_K2;
				S_K2: begin
					np_q    <= sat32(wide_t'(np_q) + ((uy_q < 0) ? -k_rnd : k_rnd));
					state_q <= S_K3;
				end
				S_K3: begin
					nx_q    <= sat32(wide_t'(nx_q) - ((ux_q < 0) ? -k_rnd : k_rnd));
					state_q <= S_K4;
				end
				S_K4: begin
					ny_q    <= sat32(wide_t'(ny_q) - ((uy_q < 0) ? -k_rnd : k_rnd));
					pret_q  <= S_CHK2;
					state_q <= P_D;
				end
				S_CHK2: begin
					if (!pok_q) begin
						fault_q <= 1'b1;
						state_q <= S_OUT;
					end else if (pass_q == PASS_W'(RELAX_PASSES - 1)) begin
						state_q <= S_OUT;
					end else begin
						pass_q  <= pass_q + 1'b1;
						state_q <= S_PASS;
					end
				end
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_fault_q  <= fault_q;
						if (fault_q) begin
							m_tdata_q <= {32'd0, cur_piny_q, cur_pinx_q, cur_pis_q};
						end else begin
							m_tdata_q <= {sat32(round_sh(wide_t'(ang_q)
								+ (wide_t'(90) <<< ANG_FRAC), ANG_SHIFT)), ny_q, nx_q, np_q};
							old_pis_q  <= cur_pis_q;
							old_pinx_q <= cur_pinx_q;
							old_piny_q <= cur_piny_q;
							cur_pis_q  <= np_q;
							cur_pinx_q <= nx_q;
							cur_piny_q <= ny_q;
						end
						state_q <= S_IDLE;
					end
				end
				N_SQA: state_q <= N_SQB;
				N_SQB: begin
					sq_acc_q <= prod_q;
					state_q  <= N_ADD;
				end
				N_ADD: begin
					sq_n_q    <= sq_acc_q + prod_q;
					sq_rem_q  <= '0;
					sq_root_q <= '0;
					cnt_q     <= '0;
					state_q   <= N_SQRT;
				end
				N_SQRT: begin
					if (sq_t >= sq_trial) begin
						sq_rem_q  <= sq_t - sq_trial;
						sq_root_q <= {sq_root_q[30:0], 1'b1};
					end else begin
						sq_rem_q  <= sq_t;
						sq_root_q <= {sq_root_q[30:0], 1'b0};
					end
					sq_n_q <= {sq_n_q[61:0], 2'b00};
					cnt_q  <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) state_q <= nret_q;
				end
				C_INIT: begin
					// The quotient stays below 2^31, so the upper dividend bits
					// start out as the partial remainder.
					dv_rem_q <= {2'b00, sd_mag[31:1]};
					dv_lo_q  <= {sd_mag[0], 30'd0};
					dv_d_q   <= {1'b0, slen_q};
					cnt_q    <= '0;
					state_q  <= C_DIV;
				end
				C_MUL: state_q <= C_RND;
				C_RND: begin
					sres_q  <= sc_res;
					state_q <= sret_q;
				end
				P_D: begin
					pdx_q   <= pdx_c;
					pdy_q   <= pdy_c;
					na_q    <= pdx_c;
					nb_q    <= pdy_c;
					nret_q  <= P_R;
					state_q <= N_SQA;
				end
				P_R: begin
					if (sq_root_q == 0) begin
						pok_q   <= 1'b0;
						state_q <= pret_q;
					end else begin
						pr_q    <= sq_root_q;
						sd_q    <= pdx_q;
						sf_q    <= sat32(rf_w);
						slen_q  <= sq_root_q;
						sret_q  <= P_X;
						state_q <= C_INIT;
					end
				end
				P_X: begin
					nx_q    <= sat32(cx_w + sres_q);
					sd_q    <= pdy_q;
					sf_q    <= sat32(rf_w);
					slen_q  <= pr_q;
					sret_q  <= P_Y;
					state_q <= C_INIT;
				end
				P_Y: begin
					ny_q    <= sat32(cy_w + sres_q);
					pok_q   <= 1'b1;
					state_q <= pret_q;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_fault_q;

	// A transfer on the input starts a step, so the input cannot take another at once.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready right after a transfer");

	// A faulted result carries a zero angle.
	a_fault_angle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[127:96] == 32'd0))
		else $error("faulted result with a nonzero angle");

	// The pass counter never runs past the last pass.
	a_pass_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pass_q < PASS_W'(RELAX_PASSES))
		else $error("pass counter out of range");

	// A new result appears only out of the output state.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_OUT))
		else $error("result raised outside the output state");

endmodule

@@ verif/solver_scoreboard.sv @@
// Checker for the crank-slider step solver: mirrors its state, predicts each step and compares.
`timescale 1ns / 1ps

module solver_scoreboard
	import csv_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [31:0]  s_tdata,   // [31:0] accel
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [127:0] m_tdata,   // [31:0] piston_y, [63:32] pin_x, [95:64] pin_y,
	                                // [127:96] rod_angle
	input  logic [0:0]   m_tuser,   // [0] fault
	input  logic         cfg_we,
	input  logic [2:0]   cfg_idx,
	input  logic [11:0]  cfg_data,
	output int           errors,
	output int           pending
);

	typedef struct packed {
		logic [31:0] piston_y;
		logic [31:0] pin_x;
		logic [31:0] pin_y;
		logic [31:0] rod_angle;
		logic        fault;
	} step_result_t;

	localparam longint ATAN_DEG [24] = '{
		754974720, 445687602, 235489089, 119537938, 60000934, 30029717,
		15018523, 7509720, 3754917, 1877466, 938734, 469367,
		234684, 117342, 58671, 29335, 14668, 7334,
		3667, 1833, 917, 458, 229, 115
	};

	step_result_t step_results_q[$];

	logic [11:0] center_x, center_y, rod_len;
	logic [9:0]  radius;
	longint piston_now, piston_prev, pin_x_now, pin_x_prev, pin_y_now, pin_y_prev;

	assign pending = step_results_q.size();

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint absval(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint unsigned root64(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic longint unsigned vec_len(longint a, longint b);
		longint unsigned ma, mb;
		ma = absval(a);
		mb = absval(b);
		return root64(ma * ma + mb * mb);
	endfunction

	// d * f / len with |d| <= len, rounded to nearest.
	function automatic longint ratio_scale(longint d, longint unsigned len, longint f);
		longint unsigned q, p;
		q = (longint'(absval(d)) << 30) / len;
		p = (q * absval(f) + (64'd1 << 29)) >> 30;
		return ((d < 0) != (f < 0)) ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint rnd_shift(longint v, int s);
		longint m;
		if (s == 0) return v;
		m = (absval(v) + (64'sd1 <<< (s - 1))) >>> s;
		return (v < 0) ? -m : m;
	endfunction

	// atan2(y, x) in degrees with 24 fraction bits, CORDIC vectoring.
	function automatic longint cordic_deg(longint y, longint x);
		longint z, t, xs, ys;
		z = 0;
		if (x == 0 && y == 0) return 0;
		x = x * 65536;
		y = y * 65536;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = 64'sd90 <<< 24;
			end else begin
				t = x; x = -y; y = t; z = -(64'sd90 <<< 24);
			end
		end
		for (int i = 0; i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys; y = y - xs; z = z + ATAN_DEG[i];
			end else begin
				x = x - ys; y = y + xs; z = z - ATAN_DEG[i];
			end
		end
		return z;
	endfunction

	// Pulls the crankpin onto the crank circle; false when it sits on the center.
	function automatic bit onto_circle(longint c_x, longint c_y, longint r_fix,
		inout longint px, inout longint py);
		longint dx, dy;
		longint unsigned r;
		dx = clamp32(px - c_x);
		dy = clamp32(py - c_y);
		r = vec_len(dx, dy);
		if (r == 0) return 0;
		px = clamp32(c_x + ratio_scale(dx, r, r_fix));
		py = clamp32(c_y + ratio_scale(dy, r, r_fix));
		return 1;
	endfunction

	function automatic step_result_t advance_step(logic [31:0] acc_bits);
		longint cxf, cyf, rf, lf, acc, am, np, nx, ny, ang, deg, vx, vy, err, ux, uy;
		longint unsigned len;
		bit fault;
		step_result_t res;
		cxf = longint'(center_x) <<< FRAC_BITS;
		cyf = longint'(center_y) <<< FRAC_BITS;
		rf = longint'(radius) <<< FRAC_BITS;
		lf = longint'(rod_len) <<< FRAC_BITS;
		acc = longint'($signed(acc_bits));
		am = (absval(acc) + 500000) / 1000000;
		if (acc < 0) am = -am;
		np = clamp32(2 * piston_now - piston_prev + am);
		nx = clamp32(2 * pin_x_now - pin_x_prev);
		ny = clamp32(2 * pin_y_now - pin_y_prev);
		ang = 0;
		fault = 0;
		for (int pass = 0; pass < RELAX_PASSES && !fault; pass++) begin
			vx = clamp32(cxf - nx);
			vy = clamp32(np - ny);
			len = vec_len(vx, vy);
			ang = cordic_deg(vy, vx);
			if (!onto_circle(cxf, cyf, rf, nx, ny) || len == 0) begin
				fault = 1;
				break;
			end
			err = clamp32(lf - longint'(len));
			ux = ratio_scale(vx, len, err);
			uy = ratio_scale(vy, len, err);
			np = clamp32(np + rnd_shift(uy * longint'(K_PISTON), FRAC_BITS));
			nx = clamp32(nx - rnd_shift(ux * longint'(K_PIN), FRAC_BITS));
			ny = clamp32(ny - rnd_shift(uy * longint'(K_PIN), FRAC_BITS));
			if (!onto_circle(cxf, cyf, rf, nx, ny)) fault = 1;
		end
		if (fault) begin
			np = piston_now; nx = pin_x_now; ny = pin_y_now; deg = 0;
		end else begin
			piston_prev = piston_now; pin_x_prev = pin_x_now; pin_y_prev = pin_y_now;
			piston_now = np; pin_x_now = nx; pin_y_now = ny;
			deg = clamp32(rnd_shift(ang + (64'sd90 <<< ANG_FRAC), ANG_FRAC - FRAC_BITS));
		end
		res.piston_y = np[31:0];
		res.pin_x = nx[31:0];
		res.pin_y = ny[31:0];
		res.rod_angle = deg[31:0];
		res.fault = fault;
		return res;
	endfunction

	task automatic report(string field, logic [31:0] got, logic [31:0] want);
		$display("mismatch on %s: got %h, expected %h", field, got, want);
		errors++;
	endtask

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		step_result_t want;
		if (!arst_n) begin
			step_results_q.delete();
			center_x <= 12'd960;
			center_y <= 12'd720;
			radius <= 10'd100;
			rod_len <= 12'd300;
			piston_now = longint'(320) <<< 16;
			piston_prev = piston_now;
			pin_x_now = longint'(960) <<< 16;
			pin_x_prev = pin_x_now;
			pin_y_now = longint'(620) <<< 16;
			pin_y_prev = pin_y_now;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_CX:  center_x <= cfg_data;
					REG_CY:  center_y <= cfg_data;
					REG_RAD: radius <= cfg_data[9:0];
					REG_LEN: rod_len <= cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (step_results_q.size() == 0) begin
					report("unexpected result", m_tdata[31:0], 32'd0);
				end else begin
					want = step_results_q.pop_front();
					if (m_tdata[31:0] !== want.piston_y)
						report("piston_y", m_tdata[31:0], want.piston_y);
					if (m_tdata[63:32] !== want.pin_x)
						report("pin_x", m_tdata[63:32], want.pin_x);
					if (m_tdata[95:64] !== want.pin_y)
						report("pin_y", m_tdata[95:64], want.pin_y);
					if (m_tdata[127:96] !== want.rod_angle)
						report("rod_angle", m_tdata[127:96], want.rod_angle);
					if (m_tuser[0] !== want.fault)
						report("fault", {31'd0, m_tuser[0]}, {31'd0, want.fault});
				end
			end
			if (s_tvalid && s_tready) step_results_q.push_back(advance_step(s_tdata));
		end
	end

endmodule

@@ verif/tb.sv @@
// Testbench top for the crank-slider step solver: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
	import csv_pkg::*;

	localparam longint CYCLE_LIMIT = 12000000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [31:0]  s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic [0:0]   m_tuser;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_idx = '0;
	logic [11:0]  cfg_data = '0;
	int           errors;
	int           pending;
	longint       cycles = 0;

	crank_slider_verlet_solver_unit uut (.*);

	solver_scoreboard checker_i (.*);

	initial forever #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// The receiver alternates between stretches of steady acceptance and random stalls.
	always @(posedge clk) begin
		if ((cycles / 20000) % 2 == 0) m_tready <= 1'b1;
		else m_tready <= ($urandom_range(0, 9) > 3);
	end

	task automatic send_accel(input logic [31:0] v);
		bit rdy;
		s_tdata <= v;
		s_tvalid <= 1'b1;
		do begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end while (!rdy);
	endtask

	task automatic pause_sender(input int n);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Waits first, so the checker has counted the transfer that just happened.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [31:0] random_accel();
		logic [31:0] v;
		v = $urandom;
		// Mostly moderate accelerations so the mechanism stays near its working range.
		if ($urandom_range(0, 3) != 0) v = {{8{v[31]}}, v[23:0]};
		return v;
	endfunction

	initial begin
		int burst;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on reset settings: rounding edges of the acceleration term.
		send_accel(32'd0);
		send_accel(32'h7fffffff);
		send_accel(32'h80000000);
		send_accel(32'd1);
		send_accel(32'hffffffff);
		send_accel(32'd499999);
		send_accel(32'd500000);
		send_accel(-32'sd500000);
		send_accel(-32'sd499999);
		send_accel(32'd0);
		wait_drained();

		// A zero radius faults and holds the state.
		write_reg(REG_RAD, 12'd0);
		send_accel(32'd1000000);
		send_accel(32'd0);
		wait_drained();
		write_reg(REG_RAD, 12'd1023);
		write_reg(REG_LEN, 12'd1);
		send_accel(32'd0);
		send_accel(32'h00100000);
		wait_drained();
		write_reg(REG_CX, 12'd0);
		write_reg(REG_CY, 12'd4095);
		write_reg(REG_LEN, 12'd4095);
		send_accel(32'h80000000);
		send_accel(32'h7fffffff);
		wait_drained();
		write_reg(REG_LEN, 12'd0);
		send_accel(32'd0);
		send_accel(32'd12345);
		wait_drained();
		write_reg(REG_CX, 12'd4095);
		write_reg(REG_CY, 12'd0);
		write_reg(REG_RAD, 12'd1);
		write_reg(REG_LEN, 12'd1);
		write_reg(3'd6, 12'hfff);
		send_accel(32'd0);
		send_accel(32'hfff00000);
		wait_drained();

		// Random phases, each with fresh register settings.
		for (int phase = 0; phase < 6; phase++) begin
			write_reg(REG_CX, 12'($urandom));
			write_reg(REG_CY, 12'($urandom));
			write_reg(REG_RAD, (phase == 5) ? 12'd1023 : 12'($urandom_range(1, 1023)));
			write_reg(REG_LEN, (phase == 4) ? 12'd4095 : 12'($urandom_range(1, 4095)));
			if (phase == 2) write_reg(3'($urandom_range(4, 7)), 12'($urandom));
			for (int n = 0; n < 100; n += burst) begin
				burst = $urandom_range(1, 8);
				for (int k = 0; k < burst; k++) send_accel(random_accel());
				pause_sender($urandom_range(0, 6));
			end
			wait_drained();
		end

		repeat (100) @(posedge clk);
		if (errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule
